// ===== hdl/selt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the shared/exclusive lock table: sizes, opcodes and status codes.
// No dependencies.
package selt_pkg;
    localparam int LOCK_SLOTS   = 16;
    localparam int SHARER_SLOTS = 8;
    localparam int LW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int SW = (SHARER_SLOTS > 1) ? $clog2(SHARER_SLOTS) : 1;

    localparam logic [1:0] MODE_LOCK    = 2'd0;
    localparam logic [1:0] MODE_UNLOCK  = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_ERR         = 2'd1;
    localparam logic [1:0] ST_WOULD_BLOCK = 2'd2;
    localparam logic [1:0] ST_MUST_WAIT   = 2'd3;

    typedef logic [SHARER_SLOTS-1:0][31:0] t_row;
endpackage

// ===== hdl/shared_exclusive_lock_table.sv =====
`timescale 1ns / 1ps
// Lock table: 16 node entries, each with an exclusive owner/count and up to 8 sharers.
// Lock/unlock: after accept, the request goes through lookup + row read, execute, result register;
// input stays stalled until the result enters the output register, so requests do not overlap.
// Release: sweeps every entry, executing each valid one; each wake but the last is emitted
// as the next is found, and the final result carries last. Output stalls hold up both.
// Sync active-low reset clears the valid bits and the output valid flag. Depends on selt_pkg.
module shared_exclusive_lock_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_node_id,
    input  logic [31:0] i_owner_id,
    input  logic [1:0]  i_lock_kind,
    input  logic        i_no_wait,
    input  logic [31:0] i_release_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_wake,
    output logic [31:0] o_wake_node_id,
    output logic        o_last
);
    localparam int LS = selt_pkg::LOCK_SLOTS;
    localparam int SS = selt_pkg::SHARER_SLOTS;
    localparam int LW = selt_pkg::LW;
    localparam int SW = selt_pkg::SW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_EXE    = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_SWRD   = 3'd4;
    localparam logic [2:0] S_SWEX   = 3'd5;
    localparam logic [2:0] S_SWNEXT = 3'd6;
    localparam logic [2:0] S_SWEND  = 3'd7;

    localparam logic [31:0] MAXV = '1;

    // control
    logic [2:0]    r_state;
    logic          r_ret_sweep;
    logic [LW-1:0] r_e;
    logic          r_pend;
    logic [31:0]   r_pend_node;

    // latched request
    logic [1:0]  r_mode;
    logic [31:0] r_node, r_owner, r_cnt;
    logic [1:0]  r_kind;
    logic        r_no_wait;

    // staged result
    logic [1:0]  r_rs_st;
    logic        r_rs_wk;
    logic [31:0] r_rs_node;
    logic        r_rs_last;

    // output register
    logic        r_ov;
    logic [1:0]  r_o_st;
    logic        r_o_wk;
    logic [31:0] r_o_node;
    logic        r_o_last;

    // per-entry state (flops); r_en compared in parallel, the rest read at r_e
    logic [LS-1:0]   r_ev;
    logic [31:0]     r_en  [LS];
    logic [31:0]     r_xo  [LS];
    logic [31:0]     r_xc  [LS];
    logic [31:0]     r_tot [LS];
    logic [SS-1:0]   r_sv  [LS];

    // sharer rows: one row per entry, registered read
    selt_pkg::t_row mem_own [LS];
    selt_pkg::t_row mem_cnt [LS];
    selt_pkg::t_row r_q_own, r_q_cnt;
    logic           mem_we;
    selt_pkg::t_row mem_wown, mem_wcnt;
    logic [LW-1:0]  rd_e;

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ov;
    assign o_status       = r_o_st;
    assign o_wake         = r_o_wk;
    assign o_wake_node_id = r_o_node;
    assign o_last         = r_o_last;

    wire out_free = !r_ov || !i_stall;

    // node lookup: hit or lowest free entry
    logic          f_hit, f_free;
    logic [LW-1:0] f_hidx, f_fidx;
    always_comb begin
        f_hit  = 1'b0;
        f_free = 1'b0;
        f_hidx = '0;
        f_fidx = '0;
        for (int i = 0; i < LS; i++) begin
            if (!f_hit && r_ev[i] && r_en[i] == r_node) begin
                f_hit  = 1'b1;
                f_hidx = LW'(i);
            end
            if (!f_free && !r_ev[i]) begin
                f_free = 1'b1;
                f_fidx = LW'(i);
            end
        end
    end

    // row address: during lookup, the entry that execute will work on
    assign rd_e = (r_state == S_FIND) ? (f_hit ? f_hidx : f_fidx) : r_e;

    // sharer lookup in the row just read
    logic          s_hit, s_free;
    logic [SW-1:0] s_hidx, s_fidx;
    logic [SS-1:0] cur_sv;
    assign cur_sv = r_sv[r_e];
    always_comb begin
        s_hit  = 1'b0;
        s_free = 1'b0;
        s_hidx = '0;
        s_fidx = '0;
        for (int s = 0; s < SS; s++) begin
            if (!s_hit && cur_sv[s] && r_q_own[s] == r_owner) begin
                s_hit  = 1'b1;
                s_hidx = SW'(s);
            end
            if (!s_free && !cur_sv[s]) begin
                s_free = 1'b1;
                s_fidx = SW'(s);
            end
        end
    end

    // lock / unlock execution
    logic [31:0]    eo, ec, et, cx;
    logic [1:0]     x_st;
    logic           x_wk;
    logic [31:0]    x_xo, x_xc, x_tot;
    logic [SS-1:0]  x_sv;
    selt_pkg::t_row x_own, x_cnt;
    logic [1:0]     busy;
    always_comb begin
        eo    = r_xo[r_e];
        ec    = r_xc[r_e];
        et    = r_tot[r_e];
        cx    = r_q_cnt[s_hidx];
        busy  = r_no_wait ? selt_pkg::ST_WOULD_BLOCK : selt_pkg::ST_MUST_WAIT;
        x_st  = selt_pkg::ST_ERR;
        x_wk  = 1'b0;
        x_xo  = eo;
        x_xc  = ec;
        x_tot = et;
        x_sv  = cur_sv;
        x_own = r_q_own;
        x_cnt = r_q_cnt;
        if (r_mode == selt_pkg::MODE_LOCK) begin
            if (r_kind[1]) begin
                if (eo == r_owner) begin
                    if (ec != MAXV) begin
                        x_xc = ec + 32'd1;
                        x_st = selt_pkg::ST_OK;
                    end
                end else if (eo == '0 && et == '0) begin
                    x_xo = r_owner;
                    x_xc = 32'd1;
                    x_st = selt_pkg::ST_OK;
                end else begin
                    x_st = busy;
                end
            end else if (r_kind[0]) begin
                if (eo != '0 && eo != r_owner) begin
                    x_st = busy;
                end else if (et != MAXV) begin
                    if (s_hit) begin
                        x_cnt[s_hidx] = cx + 32'd1;
                        x_tot = et + 32'd1;
                        x_st  = selt_pkg::ST_OK;
                    end else if (s_free) begin
                        x_sv[s_fidx]  = 1'b1;
                        x_own[s_fidx] = r_owner;
                        x_cnt[s_fidx] = 32'd1;
                        x_tot = et + 32'd1;
                        x_st  = selt_pkg::ST_OK;
                    end
                end
            end
        end else if (r_cnt != '0) begin
            if (r_kind[1]) begin
                if (eo == r_owner && ec != '0) begin
                    x_st = selt_pkg::ST_OK;
                    if (r_cnt >= ec) begin
                        x_xc = '0;
                        x_xo = '0;
                        x_wk = 1'b1;
                    end else begin
                        x_xc = ec - r_cnt;
                    end
                end
            end else if (r_kind[0]) begin
                if (s_hit && cx != '0) begin
                    x_st = selt_pkg::ST_OK;
                    if (r_cnt >= cx) begin
                        x_tot = et - cx;
                        x_sv[s_hidx]  = 1'b0;
                        x_cnt[s_hidx] = '0;
                    end else begin
                        x_cnt[s_hidx] = cx - r_cnt;
                        x_tot = et - r_cnt;
                    end
                    x_wk = (x_tot == '0) && (eo == '0);
                end
            end
        end
    end

    // release sweep step for entry r_e
    logic          w_chg, w_wake;
    logic [31:0]   w_xo, w_tot;
    logic [SS-1:0] w_sv;
    always_comb begin
        w_chg = (r_xo[r_e] == r_owner);
        w_xo  = w_chg ? '0 : r_xo[r_e];
        w_tot = r_tot[r_e];
        w_sv  = cur_sv;
        if (s_hit) begin
            w_tot = r_tot[r_e] - cx;
            w_sv[s_hidx] = 1'b0;
            w_chg = 1'b1;
        end
        w_wake = w_chg && w_xo == '0 && w_tot == '0;
    end

    always_comb begin
        mem_we   = (r_state == S_EXE);
        mem_wown = x_own;
        mem_wcnt = x_cnt;
    end

    // sharer row memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_own[r_e] <= mem_wown;
            mem_cnt[r_e] <= mem_wcnt;
        end
        r_q_own <= mem_own[rd_e];
        r_q_cnt <= mem_cnt[rd_e];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_o_st   <= r_rs_st;
            r_o_wk   <= r_rs_wk;
            r_o_node <= r_rs_node;
            r_o_last <= r_rs_last;
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret_sweep <= 1'b0;
            r_pend      <= 1'b0;
            r_e         <= '0;
            r_ev        <= '0;
            for (int i = 0; i < LS; i++) begin
                r_sv[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode    <= i_mode;
                        r_node    <= i_node_id;
                        r_owner   <= i_owner_id;
                        r_kind    <= i_lock_kind;
                        r_no_wait <= i_no_wait;
                        r_cnt     <= i_release_count;
                        r_state   <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_rs_st     <= selt_pkg::ST_ERR;
                    r_rs_wk     <= 1'b0;
                    r_rs_node   <= '0;
                    r_rs_last   <= 1'b1;
                    r_ret_sweep <= 1'b0;
                    if (r_owner == '0 || !(r_mode inside {selt_pkg::MODE_LOCK,
                            selt_pkg::MODE_UNLOCK, selt_pkg::MODE_RELEASE})) begin
                        r_state <= S_EMIT;
                    end else if (r_mode == selt_pkg::MODE_RELEASE) begin
                        r_e     <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SWRD;
                    end else if (f_hit) begin
                        r_e     <= f_hidx;
                        r_state <= S_EXE;
                    end else if (f_free) begin
                        // allocate lowest free entry
                        r_e            <= f_fidx;
                        r_ev[f_fidx]   <= 1'b1;
                        r_en[f_fidx]   <= r_node;
                        r_xo[f_fidx]   <= '0;
                        r_xc[f_fidx]   <= '0;
                        r_tot[f_fidx]  <= '0;
                        r_sv[f_fidx]   <= '0;
                        r_state        <= S_EXE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EXE: begin
                    // row read issued in the previous cycle is in r_q_*
                    r_xo[r_e]  <= x_xo;
                    r_xc[r_e]  <= x_xc;
                    r_tot[r_e] <= x_tot;
                    r_sv[r_e]  <= x_sv;
                    r_rs_st    <= x_st;
                    r_rs_wk    <= x_wk;
                    r_rs_node  <= x_wk ? r_node : '0;
                    r_rs_last  <= 1'b1;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= r_ret_sweep ? S_SWNEXT : S_IDLE;
                    end
                end
                S_SWRD: begin
                    r_state <= r_ev[r_e] ? S_SWEX : S_SWNEXT;
                end
                S_SWEX: begin
                    r_xo[r_e]  <= w_xo;
                    if (w_chg && w_xo == '0) begin
                        r_xc[r_e] <= '0;
                    end
                    r_tot[r_e] <= w_tot;
                    r_sv[r_e]  <= w_sv;
                    if (w_wake) begin
                        // hold one wake back so the final one can carry last
                        r_pend      <= 1'b1;
                        r_pend_node <= r_en[r_e];
                    end
                    if (w_wake && r_pend) begin
                        r_rs_st     <= selt_pkg::ST_OK;
                        r_rs_wk     <= 1'b1;
                        r_rs_node   <= r_pend_node;
                        r_rs_last   <= 1'b0;
                        r_ret_sweep <= 1'b1;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state     <= S_SWNEXT;
                    end
                end
                S_SWNEXT: begin
                    if (r_e == LW'(LS - 1)) begin
                        r_state <= S_SWEND;
                    end else begin
                        r_e     <= r_e + LW'(1);
                        r_state <= S_SWRD;
                    end
                end
                S_SWEND: begin
                    r_rs_st     <= selt_pkg::ST_OK;
                    r_rs_wk     <= r_pend;
                    r_rs_node   <= r_pend ? r_pend_node : '0;
                    r_rs_last   <= 1'b1;
                    r_ret_sweep <= 1'b0;
                    r_pend      <= 1'b0;
                    r_state     <= S_EMIT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a wake result is always a success
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wake |-> o_status == selt_pkg::ST_OK)
        else $error("wake with non-ok status");
    // no wake means no node reported
    a_node_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_wake |-> o_wake_node_id == '0)
        else $error("node reported without wake");
    // memory row is written only right after a lookup
    a_wr_after_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXE |-> $past(r_state) == S_FIND)
        else $error("execute without lookup");
`endif
endmodule
